FILE: design/rhpp_pkg.sv
// ----------------------------------------------------------------------------
// rhpp_pkg
// Shared types and constants of the rendezvous hash peer picker: field widths,
// hash constants, command queue entry, result and state encodings.
// ----------------------------------------------------------------------------
package rhpp_pkg;

  // default sizes
  localparam int PEER_SLOTS_DEF = 32;
  localparam int NAME_BYTES_DEF = 20;
  localparam int CMD_FIFO_DEPTH = 4;

  // field widths
  localparam int PEER_IDX_W = 5;
  localparam int PEER_CNT_W = 6;
  localparam int HASH_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 8;

  // hash constants
  localparam logic [HASH_W-1:0] LCG_MUL  = 32'd1103515245;
  localparam logic [HASH_W-1:0] LCG_ADD  = 32'd12345;
  localparam logic [HASH_W-1:0] LOW31    = 32'h7FFF_FFFF;
  localparam int                NAME_ROT = 19;

  // kind of input item
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_NAME  = 1'b1
  } action_e;

  // kind of queued command
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SCAN  = 1'b1
  } cmd_kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEER_COUNT  = 1'b0,
    CFG_LOCAL_INDEX = 1'b1
  } cfg_reg_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_DONE
  } back_state_e;

  // command from the front end to the back end
  typedef struct packed {
    cmd_kind_e              kind;
    logic [PEER_IDX_W-1:0]  index;
    logic [HASH_W-1:0]      hash;
    logic                   alive;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic                   pick_valid;
    logic [PEER_IDX_W-1:0]  picked_peer;
  } result_t;

endpackage

FILE: design/rhpp_ram.sv
// ----------------------------------------------------------------------------
// rhpp_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rhpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/rhpp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rhpp_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rhpp_cmd_fifo #(
  parameter int DEPTH = rhpp_pkg::CMD_FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rhpp_pkg::cmd_t data_i,
  input  logic           pop_i,
  output rhpp_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  rhpp_pkg::cmd_t  mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: design/rhpp_front.sv
// ----------------------------------------------------------------------------
// rhpp_front
// Front end: accepts items, folds name bytes into the running name hash and
// queues table writes and completed-name scans for the back end.
// ----------------------------------------------------------------------------
module rhpp_front #(
  parameter int PEER_SLOTS = rhpp_pkg::PEER_SLOTS_DEF,
  parameter int NAME_BYTES = rhpp_pkg::NAME_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_action_i,
  input  logic [rhpp_pkg::PEER_IDX_W-1:0] in_index_i,
  input  logic [rhpp_pkg::HASH_W-1:0]     in_hash_i,
  input  logic                            in_alive_i,
  input  logic [rhpp_pkg::BYTE_W-1:0]     in_byte_i,
  input  logic                            full_i,
  output logic                            push_o,
  output rhpp_pkg::cmd_t                  cmd_o
);

  localparam int ByteCntW = $clog2(NAME_BYTES + 1);
  localparam int HashW    = rhpp_pkg::HASH_W;
  localparam int RotLo    = HashW - rhpp_pkg::NAME_ROT;

  logic [HashW-1:0]    hash_q, hash_d;
  logic [ByteCntW-1:0] cnt_q, cnt_d;
  logic                accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // running hash and command build
  always_comb begin
    logic [HashW-1:0] rot;
    logic [HashW-1:0] sext;
    logic [HashW-1:0] sum;
    rot    = {hash_q[RotLo-1:0], hash_q[HashW-1:RotLo]};
    sext   = {{(HashW - rhpp_pkg::BYTE_W){in_byte_i[rhpp_pkg::BYTE_W-1]}}, in_byte_i};
    sum    = hash_q + rot + sext;
    hash_d = hash_q;
    cnt_d  = cnt_q;
    push_o = 1'b0;
    cmd_o  = '{kind: rhpp_pkg::CMD_WRITE, index: in_index_i, hash: in_hash_i,
               alive: in_alive_i};
    if (accept) begin
      if (rhpp_pkg::action_e'(in_action_i) == rhpp_pkg::ACT_WRITE) begin
        // writes beyond the table are dropped here
        push_o = (32'(in_index_i) < 32'(PEER_SLOTS));
      end else if (cnt_q == ByteCntW'(NAME_BYTES - 1)) begin
        // last byte of a name: hand the hash to the back end
        push_o = 1'b1;
        cmd_o  = '{kind: rhpp_pkg::CMD_SCAN, index: '0, hash: sum, alive: 1'b0};
        hash_d = '0;
        cnt_d  = '0;
      end else begin
        hash_d = sum;
        cnt_d  = cnt_q + ByteCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      cnt_q  <= '0;
    end else begin
      hash_q <= hash_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: design/rhpp_back.sv
// ----------------------------------------------------------------------------
// rhpp_back
// Back end: applies table writes and, for each completed name, walks the
// peer table through a weight pipeline and keeps the running maximum.
// ----------------------------------------------------------------------------
module rhpp_back #(
  parameter int PEER_SLOTS = rhpp_pkg::PEER_SLOTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rhpp_pkg::cmd_t                       head_i,
  input  logic                                 empty_i,
  output logic                                 pop_o,
  input  logic [$clog2(PEER_SLOTS + 1)-1:0]    limit_i,
  input  logic [rhpp_pkg::PEER_IDX_W-1:0]      local_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output rhpp_pkg::result_t                    out_o
);

  localparam int IdxW  = $clog2(PEER_SLOTS);
  localparam int CntW  = $clog2(PEER_SLOTS + 1);
  localparam int HashW = rhpp_pkg::HASH_W;
  localparam int WW    = HashW - 1;

  rhpp_pkg::back_state_e state_q, state_d;
  logic [CntW-1:0]       scan_cnt_q;
  logic [IdxW-1:0]       scan_idx;
  logic [WW-1:0]         name_hash_q;
  logic [PEER_SLOTS-1:0] alive_q;
  logic                  pop, ram_we, issue, scan_start, load_out;
  logic [HashW-1:0]      ram_rdata;

  // weight pipeline stages
  logic             va_q, vb_q, vc_q, vd_q;
  logic             ca_q, cb_q, cc_q, cd_q;
  logic [IdxW-1:0]  ia_q, ib_q, ic_q, id_q;
  logic [HashW-1:0] prod1_q, mixed_q, prod2_q;
  logic [WW-1:0]    weight;

  // running maximum
  logic             found_q;
  logic [WW-1:0]    best_w_q;
  logic [IdxW-1:0]  best_i_q;

  logic              out_valid_q;
  rhpp_pkg::result_t out_q;

  function automatic logic [HashW-1:0] LcgMul(input logic [HashW-1:0] x);
    logic [HashW-1:0] p;
    p = rhpp_pkg::LCG_MUL * x;
    return p;
  endfunction

  assign scan_idx    = scan_cnt_q[IdxW-1:0];
  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  rhpp_ram #(
    .WIDTH (HashW),
    .DEPTH (PEER_SLOTS)
  ) u_hash_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IdxW'(head_i.index)),
    .wdata_i (head_i.hash),
    .raddr_i (scan_idx),
    .rdata_o (ram_rdata)
  );

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    pop        = 1'b0;
    ram_we     = 1'b0;
    issue      = 1'b0;
    scan_start = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      rhpp_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop = 1'b1;
          if (head_i.kind == rhpp_pkg::CMD_WRITE) begin
            ram_we = 1'b1;
          end else begin
            scan_start = 1'b1;
            state_d    = rhpp_pkg::BK_SCAN;
          end
        end
      end
      rhpp_pkg::BK_SCAN: begin
        if (scan_cnt_q < limit_i) begin
          issue = 1'b1;
        end else begin
          state_d = rhpp_pkg::BK_DRAIN;
        end
      end
      rhpp_pkg::BK_DRAIN: begin
        if (!(va_q || vb_q || vc_q || vd_q)) begin
          state_d = rhpp_pkg::BK_DONE;
        end
      end
      rhpp_pkg::BK_DONE: begin
        if (!out_valid_q) begin
          load_out = 1'b1;
          state_d  = rhpp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = rhpp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rhpp_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // scan counter and alive flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      alive_q    <= '0;
    end else begin
      if (scan_start) begin
        scan_cnt_q <= '0;
      end else if (issue) begin
        scan_cnt_q <= scan_cnt_q + CntW'(1);
      end
      if (ram_we) begin
        alive_q[IdxW'(head_i.index)] <= head_i.alive;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_start) begin
      name_hash_q <= head_i.hash[WW-1:0];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      va_q <= issue;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  // pipeline payload: read, first multiply, mix, second multiply
  always_ff @(posedge clk_i) begin
    ca_q    <= alive_q[scan_idx] && (32'(scan_idx) != 32'(local_i));
    ia_q    <= scan_idx;
    cb_q    <= ca_q;
    ib_q    <= ia_q;
    prod1_q <= LcgMul(ram_rdata & rhpp_pkg::LOW31);
    cc_q    <= cb_q;
    ic_q    <= ib_q;
    mixed_q <= (prod1_q + rhpp_pkg::LCG_ADD) ^ {1'b0, name_hash_q};
    cd_q    <= cc_q;
    id_q    <= ic_q;
    prod2_q <= LcgMul(mixed_q);
  end

  assign weight = prod2_q[WW-1:0] + rhpp_pkg::LCG_ADD[WW-1:0];

  // running maximum, earlier index kept on a tie
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (scan_start) begin
      found_q <= 1'b0;
    end else if (vd_q && cd_q) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vd_q && cd_q && (!found_q || weight > best_w_q)) begin
      best_w_q <= weight;
      best_i_q <= id_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.pick_valid  <= found_q;
      out_q.picked_peer <= found_q ? rhpp_pkg::PEER_IDX_W'(best_i_q) : '0;
    end
  end

  // pipeline is empty whenever no scan is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rhpp_pkg::BK_IDLE || state_q == rhpp_pkg::BK_DONE)
      |-> !(va_q || vb_q || vc_q || vd_q))
    else $error("weight pipeline busy outside a scan");

  // a reported peer lies inside the table range and is not the local node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rhpp_pkg::BK_DONE && found_q)
      |-> (32'(best_i_q) < 32'(limit_i)) && (32'(best_i_q) != 32'(local_i)))
    else $error("picked peer out of range or local");

  // the scan never runs past the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rhpp_pkg::BK_SCAN) |-> (scan_cnt_q <= limit_i))
    else $error("scan counter beyond limit");

  // a result is loaded only after the scan has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> $past(state_q) == rhpp_pkg::BK_DRAIN || $past(state_q) == rhpp_pkg::BK_DONE)
    else $error("result loaded without a finished scan");

endmodule

FILE: design/rendezvous_hash_peer_pick_top.sv
// ----------------------------------------------------------------------------
// rendezvous_hash_peer_pick_top
// Rendezvous peer picker: peer table writes and chunk name bytes come in on
// one stream, one pick per completed name goes out on the other.
// ----------------------------------------------------------------------------
// Input items are taken one per cycle while the 4-entry command queue has room.
// A completed name holds the back end for one table read per entry, over
// min(peer_count,PEER_SLOTS) entries, plus the weight pipeline drain. The pick
// then goes to the output register once any earlier pick has been taken,
// behind any queue wait. Reset clears alive flags, name hash, configuration and
// queue; the hash table is left undefined and needs no clearing pass.
module rendezvous_hash_peer_pick_top #(
  parameter int PEER_SLOTS = rhpp_pkg::PEER_SLOTS_DEF,
  parameter int NAME_BYTES = rhpp_pkg::NAME_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: peer_index[4:0], peer_hash[36:5], peer_alive[37], name_byte[45:38]
  input  logic [rhpp_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser: action[0]
  input  logic                             s_axis_tuser_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: picked_peer[4:0]
  output logic [rhpp_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // tuser: pick_valid[0]
  output logic                             m_axis_tuser_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic                             cfg_we_i,
  input  logic [rhpp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rhpp_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int CntW = $clog2(PEER_SLOTS + 1);
  localparam int IdxW = rhpp_pkg::PEER_IDX_W;

  logic [rhpp_pkg::PEER_CNT_W-1:0] peer_count_q;
  logic [IdxW-1:0]                 local_q;
  logic [CntW-1:0]                 limit;
  logic                            push, pop, empty, full;
  rhpp_pkg::cmd_t                  push_cmd, head_cmd;
  rhpp_pkg::result_t               result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_count_q <= '0;
      local_q      <= '0;
    end else if (cfg_we_i) begin
      case (rhpp_pkg::cfg_reg_e'(cfg_idx_i))
        rhpp_pkg::CFG_PEER_COUNT:  peer_count_q <= cfg_wdata_i;
        rhpp_pkg::CFG_LOCAL_INDEX: local_q      <= cfg_wdata_i[IdxW-1:0];
        default: ;
      endcase
    end
  end

  // peer count saturates at the table size
  assign limit = (32'(peer_count_q) < 32'(PEER_SLOTS)) ? CntW'(peer_count_q)
                                                       : CntW'(PEER_SLOTS);

  rhpp_front #(
    .PEER_SLOTS (PEER_SLOTS),
    .NAME_BYTES (NAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (s_axis_tuser_i),
    .in_index_i  (s_axis_tdata_i[4:0]),
    .in_hash_i   (s_axis_tdata_i[36:5]),
    .in_alive_i  (s_axis_tdata_i[37]),
    .in_byte_i   (s_axis_tdata_i[45:38]),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  rhpp_cmd_fifo #(
    .DEPTH (rhpp_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  rhpp_back #(
    .PEER_SLOTS (PEER_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .limit_i     (limit),
    .local_i     (local_q),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_o       (result)
  );

  // result packing
  assign m_axis_tuser_o = result.pick_valid;
  assign m_axis_tdata_o = {(rhpp_pkg::M_TDATA_W - IdxW)'(0), result.picked_peer};

endmodule
